FILE: hw/rtl/csv_byte_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef CSV_BYTE_TOKENIZER_ASSERT_SVH
`define CSV_BYTE_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

FILE: hw/rtl/cbt_pkg.sv
`default_nettype none

package cbt_pkg;

    localparam int COL_W = 8;
    localparam int ROW_W = 16;
    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
    localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

    localparam int FIFO_AW = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [7:0] BYTE_LF = 8'd10;
    localparam logic [7:0] BYTE_CR = 8'd13;
    localparam logic [7:0] BYTE_QUOTE = 8'h22;
    localparam logic [7:0] BYTE_COMMA = 8'd44;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_BYTE = 2'd1;
    localparam logic [1:0] ERR_CR = 2'd2;

    typedef struct packed {
        logic nul;
        logic dlm;
        logic lf;
        logic cr;
        logic quo;
        logic txt;
        logic comma;
    } t_cls;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eot;
        t_cls       cls;
    } t_item;

    typedef struct packed {
        logic [7:0]       echo_byte;
        logic             is_content;
        logic             field_done;
        logic             empty_field;
        logic             row_done;
        logic [COL_W-1:0] column_index;
        logic [ROW_W-1:0] row_index;
        logic [1:0]       err_code;
        logic             stream_end;
    } t_res;

endpackage

`default_nettype wire

FILE: hw/rtl/cbt_front.sv
`default_nettype none

module cbt_front (
    input  wire logic           i_tvalid,
    output logic                o_tready,
    input  wire logic [7:0]     i_tdata,
    input  wire logic           i_tlast,
    input  wire logic [7:0]     i_delim,
    input  wire logic           i_full,
    output logic                o_push,
    output cbt_pkg::t_item      o_item
);

    logic [7:0] b;

    assign b = i_tdata;
    assign o_tready = !i_full;
    assign o_push = i_tvalid && !i_full;

    always_comb begin
        o_item.data_byte = b;
        o_item.eot = i_tlast;
        o_item.cls.nul = (b == 8'd0);
        o_item.cls.dlm = (b == i_delim);
        o_item.cls.lf = (b == cbt_pkg::BYTE_LF);
        o_item.cls.cr = (b == cbt_pkg::BYTE_CR);
        o_item.cls.quo = (b == cbt_pkg::BYTE_QUOTE);
        o_item.cls.comma = (b == cbt_pkg::BYTE_COMMA);
        o_item.cls.txt = (b != i_delim) &&
                         (b inside {8'd32, 8'd33, [8'd35:8'd43], [8'd45:8'd255]});
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cbt_fifo.sv
`default_nettype none

`include "csv_byte_tokenizer_assert.svh"

module cbt_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cbt_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output cbt_pkg::t_item      o_item
);

    localparam logic [cbt_pkg::FIFO_AW:0] FIFO_FULL = (cbt_pkg::FIFO_AW + 1)'(cbt_pkg::FIFO_DEPTH);

    cbt_pkg::t_item r_mem [cbt_pkg::FIFO_DEPTH];
    logic [cbt_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [cbt_pkg::FIFO_AW:0]   r_count;

    assign o_full = (r_count == FIFO_FULL);
    assign o_valid = (r_count != '0);
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CBT_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, r_count != FIFO_FULL)

endmodule

`default_nettype wire

FILE: hw/rtl/cbt_back.sv
`default_nettype none

`include "csv_byte_tokenizer_assert.svh"

module cbt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire cbt_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output cbt_pkg::t_res       o_res
);

    typedef enum logic [6:0] {
        M_START    = 7'b0000001,
        M_ITEM     = 7'b0000010,
        M_QUOTED   = 7'b0000100,
        M_QSEEN    = 7'b0001000,
        M_CR       = 7'b0010000,
        M_ERR_BYTE = 7'b0100000,
        M_ERR_CR   = 7'b1000000
    } t_mode;

    t_mode r_mode, n_mode;
    logic r_exp, n_exp;
    logic [cbt_pkg::COL_W-1:0] r_col, n_col, col_inc;
    logic [cbt_pkg::ROW_W-1:0] r_row, n_row, row_inc;
    cbt_pkg::t_res r_res, n_res;
    logic r_ovalid;
    logic bad;
    cbt_pkg::t_cls c;

    assign o_pop = i_valid && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_res = r_res;
    assign c = i_item.cls;
    assign col_inc = (r_col == cbt_pkg::COL_MAX) ? r_col : r_col + 1'b1;
    assign row_inc = (r_row == cbt_pkg::ROW_MAX) ? r_row : r_row + 1'b1;

    always_comb begin
        n_mode = r_mode;
        n_exp = r_exp;
        n_col = r_col;
        n_row = r_row;
        bad = 1'b0;
        n_res.echo_byte = i_item.data_byte;
        n_res.is_content = 1'b0;
        n_res.field_done = 1'b0;
        n_res.empty_field = 1'b0;
        n_res.row_done = 1'b0;
        n_res.column_index = r_col;
        n_res.row_index = r_row;
        n_res.err_code = cbt_pkg::ERR_NONE;
        n_res.stream_end = i_item.eot;

        case (r_mode)
            M_START: begin
                if (c.nul) begin
                    bad = 1'b1;
                end else if (c.dlm) begin
                    n_res.empty_field = r_exp;
                    n_col = col_inc;
                    n_exp = 1'b1;
                end else if (c.lf) begin
                    n_res.empty_field = r_exp;
                    n_res.row_done = 1'b1;
                    n_col = '0;
                    n_row = row_inc;
                    n_exp = 1'b1;
                    n_mode = M_START;
                end else if (c.cr) begin
                    n_mode = M_CR;
                end else if (c.quo) begin
                    n_res.is_content = 1'b1;
                    n_exp = 1'b0;
                    n_mode = M_QUOTED;
                end else if (c.txt) begin
                    n_res.is_content = 1'b1;
                    n_exp = 1'b0;
                    n_mode = M_ITEM;
                end else begin
                    bad = 1'b1;
                end
            end
            M_ITEM, M_QSEEN: begin
                if (c.nul) begin
                    bad = 1'b1;
                end else if (r_mode == M_QSEEN && c.quo) begin
                    n_res.is_content = 1'b1;
                    n_mode = M_QUOTED;
                end else if (c.dlm) begin
                    n_res.field_done = 1'b1;
                    n_col = col_inc;
                    n_exp = 1'b1;
                    n_mode = M_START;
                end else if (c.lf) begin
                    n_res.field_done = 1'b1;
                    n_res.row_done = 1'b1;
                    n_col = '0;
                    n_row = row_inc;
                    n_exp = 1'b1;
                    n_mode = M_START;
                end else if (c.cr) begin
                    n_res.field_done = 1'b1;
                    n_exp = 1'b0;
                    n_mode = M_CR;
                end else if (r_mode == M_ITEM && c.txt) begin
                    n_res.is_content = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            M_QUOTED: begin
                if (c.nul) begin
                    bad = 1'b1;
                end else if (c.quo) begin
                    n_res.is_content = 1'b1;
                    n_mode = M_QSEEN;
                end else if (c.txt || c.lf || c.cr || c.comma || c.dlm) begin
                    n_res.is_content = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            M_CR: begin
                if (c.lf) begin
                    n_res.empty_field = r_exp;
                    n_res.row_done = 1'b1;
                    n_col = '0;
                    n_row = row_inc;
                    n_exp = 1'b1;
                    n_mode = M_START;
                end else begin
                    n_res.err_code = cbt_pkg::ERR_CR;
                    n_mode = M_ERR_CR;
                end
            end
            M_ERR_BYTE: begin
                n_res.err_code = cbt_pkg::ERR_BYTE;
            end
            default: begin
                n_res.err_code = cbt_pkg::ERR_CR;
                n_mode = M_ERR_CR;
            end
        endcase

        if (bad) begin
            n_res.is_content = 1'b0;
            n_res.field_done = 1'b0;
            n_res.empty_field = 1'b0;
            n_res.row_done = 1'b0;
            n_res.err_code = cbt_pkg::ERR_BYTE;
            n_mode = M_ERR_BYTE;
        end

        if (i_item.eot) begin
            if (n_mode inside {M_ITEM, M_QUOTED, M_QSEEN}) begin
                n_res.field_done = 1'b1;
            end else if (n_mode == M_CR) begin
                n_res.err_code = cbt_pkg::ERR_CR;
                n_mode = M_ERR_CR;
            end
            if (!(n_mode inside {M_ERR_BYTE, M_ERR_CR})) begin
                n_mode = M_START;
                n_exp = 1'b1;
                n_col = '0;
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_exp <= 1'b1;
            r_col <= '0;
            r_row <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode <= n_mode;
                r_exp <= n_exp;
                r_col <= n_col;
                r_row <= n_row;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    `CBT_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_mode == M_ERR_BYTE, r_mode == M_ERR_BYTE)
    `CBT_ASSERT_NOW(a_err_no_flags, i_clk, i_rst_n, r_ovalid && r_res.err_code != cbt_pkg::ERR_NONE, !r_res.is_content && !r_res.empty_field && !r_res.row_done)
    `CBT_ASSERT_NEXT(a_row_clears_col, i_clk, i_rst_n, o_pop && n_res.row_done, r_col == '0)

endmodule

`default_nettype wire

FILE: hw/rtl/csv_byte_tokenizer.sv
`default_nettype none

// CSV tokenizer, one text byte per word, RFC 4180 style with a separator byte set
// through the APB register at address 0 (comma after reset). Each input word yields
// exactly one result word that tags the byte as field text and reports field ends,
// empty fields, row ends, column and row index and a sticky error code. The block
// sustains one byte per clock cycle while the output is taken; that rate is set by
// the per-byte state update of the scanner state machine in the back end. A
// byte accepted at the input passes through a four-word queue between the byte
// classifier and the scanner, which absorbs short stalls on either side, and is
// then popped by the scanner into its registered result word.

module csv_byte_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // text_byte
    input  wire logic [7:0]  i_s_tdata,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // echo_byte, is_content, field_done, empty_field, row_done,
    // column_index, row_index, err_code, zero fill
    output logic [39:0]      o_m_tdata,
    output logic             o_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] r_delim;
    logic push, full, pop, q_valid;
    cbt_pkg::t_item front_item, q_item;
    cbt_pkg::t_res res;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, r_delim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= cbt_pkg::DELIM_RESET;
        end else if (psel && penable && pwrite) begin
            r_delim <= pwdata[7:0];
        end
    end

    cbt_front u_front (
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .i_delim  (r_delim),
        .i_full   (full),
        .o_push   (push),
        .o_item   (front_item)
    );

    cbt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cbt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {2'b00, res.err_code, res.row_index, res.column_index,
                        res.row_done, res.empty_field, res.field_done,
                        res.is_content, res.echo_byte};
    assign o_m_tlast = res.stream_end;

endmodule

`default_nettype wire

FILE: dv/csv_byte_tokenizer_tb.sv
`timescale 1ns / 1ps

module csv_byte_tokenizer_tb;

    localparam logic [1:0] DELIM_ADDR = 2'd0;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
    } t_text_word;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_FIELD,
        SCAN_QUOTED,
        SCAN_QUOTE_SEEN,
        SCAN_CR,
        SCAN_ERR_BYTE,
        SCAN_ERR_CR
    } t_scan;

    typedef enum int {
        FAULT_CTRL,
        FAULT_COMMA,
        FAULT_QUOTE_IN_FIELD,
        FAULT_AFTER_CLOSE,
        FAULT_CTRL_QUOTED,
        FAULT_BARE_CR,
        FAULT_FINAL_CR
    } t_fault;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // echo_byte, is_content, field_done, empty_field, row_done,
    // column_index, row_index, err_code, zero fill
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_text_word                text_q[$];
    cbt_pkg::t_res             expected_tags[$];
    t_scan                     scan = SCAN_START;
    logic                      want_field = 1'b1;
    logic [cbt_pkg::COL_W-1:0] col_cnt = '0;
    logic [cbt_pkg::ROW_W-1:0] row_cnt = '0;
    logic [7:0]                sep_byte = cbt_pkg::DELIM_RESET;
    bit                        took = 1'b0;
    int                        cyc = 0;
    int                        fails = 0;

    csv_byte_tokenizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit is_text(input logic [7:0] b);
        return b != sep_byte && (b == 8'd32 || b == 8'd33 ||
               (b >= 8'd35 && b <= 8'd43) || b >= 8'd45);
    endfunction

    function automatic void close_row();
        col_cnt = '0;
        if (row_cnt != cbt_pkg::ROW_MAX) row_cnt = row_cnt + 1'b1;
        want_field = 1'b1;
        scan = SCAN_START;
    endfunction

    function automatic cbt_pkg::t_res tokenize_byte(input logic [7:0] b, input logic eot);
        cbt_pkg::t_res r;
        logic bad;
        r = '0;
        bad = 1'b0;
        r.echo_byte = b;
        r.column_index = col_cnt;
        r.row_index = row_cnt;
        r.err_code = cbt_pkg::ERR_NONE;
        r.stream_end = eot;
        case (scan)
            SCAN_START: begin
                if (b == 8'd0) begin
                    bad = 1'b1;
                end else if (b == sep_byte) begin
                    r.empty_field = want_field;
                    if (col_cnt != cbt_pkg::COL_MAX) col_cnt = col_cnt + 1'b1;
                    want_field = 1'b1;
                end else if (b == cbt_pkg::BYTE_LF) begin
                    r.empty_field = want_field;
                    r.row_done = 1'b1;
                    close_row();
                end else if (b == cbt_pkg::BYTE_CR) begin
                    scan = SCAN_CR;
                end else if (b == cbt_pkg::BYTE_QUOTE) begin
                    r.is_content = 1'b1;
                    want_field = 1'b0;
                    scan = SCAN_QUOTED;
                end else if (is_text(b)) begin
                    r.is_content = 1'b1;
                    want_field = 1'b0;
                    scan = SCAN_FIELD;
                end else begin
                    bad = 1'b1;
                end
            end
            SCAN_FIELD, SCAN_QUOTE_SEEN: begin
                if (b == 8'd0) begin
                    bad = 1'b1;
                end else if (scan == SCAN_QUOTE_SEEN && b == cbt_pkg::BYTE_QUOTE) begin
                    r.is_content = 1'b1;
                    scan = SCAN_QUOTED;
                end else if (b == sep_byte) begin
                    r.field_done = 1'b1;
                    if (col_cnt != cbt_pkg::COL_MAX) col_cnt = col_cnt + 1'b1;
                    want_field = 1'b1;
                    scan = SCAN_START;
                end else if (b == cbt_pkg::BYTE_LF) begin
                    r.field_done = 1'b1;
                    r.row_done = 1'b1;
                    close_row();
                end else if (b == cbt_pkg::BYTE_CR) begin
                    r.field_done = 1'b1;
                    want_field = 1'b0;
                    scan = SCAN_CR;
                end else if (scan == SCAN_FIELD && is_text(b)) begin
                    r.is_content = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            SCAN_QUOTED: begin
                if (b == 8'd0) begin
                    bad = 1'b1;
                end else if (b == cbt_pkg::BYTE_QUOTE) begin
                    r.is_content = 1'b1;
                    scan = SCAN_QUOTE_SEEN;
                end else if (is_text(b) || b == cbt_pkg::BYTE_LF || b == cbt_pkg::BYTE_CR ||
                             b == cbt_pkg::BYTE_COMMA || b == sep_byte) begin
                    r.is_content = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            SCAN_CR: begin
                if (b == cbt_pkg::BYTE_LF) begin
                    r.empty_field = want_field;
                    r.row_done = 1'b1;
                    close_row();
                end else begin
                    r.err_code = cbt_pkg::ERR_CR;
                    scan = SCAN_ERR_CR;
                end
            end
            SCAN_ERR_BYTE: begin
                r.err_code = cbt_pkg::ERR_BYTE;
            end
            default: begin
                r.err_code = cbt_pkg::ERR_CR;
                scan = SCAN_ERR_CR;
            end
        endcase
        if (bad) begin
            r.is_content = 1'b0;
            r.field_done = 1'b0;
            r.empty_field = 1'b0;
            r.row_done = 1'b0;
            r.err_code = cbt_pkg::ERR_BYTE;
            scan = SCAN_ERR_BYTE;
        end
        if (eot) begin
            if (scan == SCAN_FIELD || scan == SCAN_QUOTED || scan == SCAN_QUOTE_SEEN) begin
                r.field_done = 1'b1;
            end else if (scan == SCAN_CR) begin
                r.err_code = cbt_pkg::ERR_CR;
                scan = SCAN_ERR_CR;
            end
            if (scan != SCAN_ERR_BYTE && scan != SCAN_ERR_CR) begin
                scan = SCAN_START;
                want_field = 1'b1;
                col_cnt = '0;
                row_cnt = '0;
            end
        end
        return r;
    endfunction

    function automatic bit gap_now();
        return ($urandom_range(99) < 33) && ((cyc % 5000) >= 1000);
    endfunction

    function automatic void check_field(input string fname, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0h, actual %0h", fname, want_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        cbt_pkg::t_res want;
        cyc++;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_tags.push_back(tokenize_byte(i_s_tdata, i_s_tlast));
            void'(text_q.pop_front());
            took = 1'b1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_tags.size() == 0) begin
                $error("result word with nothing expected: tdata %h", o_m_tdata);
                fails++;
            end else begin
                want = expected_tags.pop_front();
                check_field("echo_byte", want.echo_byte, o_m_tdata[7:0]);
                check_field("is_content", want.is_content, o_m_tdata[8]);
                check_field("field_done", want.field_done, o_m_tdata[9]);
                check_field("empty_field", want.empty_field, o_m_tdata[10]);
                check_field("row_done", want.row_done, o_m_tdata[11]);
                check_field("column_index", want.column_index, o_m_tdata[19:12]);
                check_field("row_index", want.row_index, o_m_tdata[35:20]);
                check_field("err_code", want.err_code, o_m_tdata[37:36]);
                check_field("stream_end", want.stream_end, o_m_tlast);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || took)) begin
            if (text_q.size() != 0 && !gap_now()) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= text_q[0].text;
                i_s_tlast <= text_q[0].eot;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        took = 1'b0;
        i_m_tready <= i_rst_n && !gap_now();
    end

    task automatic put_word(input logic [7:0] b, input logic eot);
        t_text_word w;
        w.text = b;
        w.eot = eot;
        text_q.push_back(w);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
    endtask

    task automatic mark_end();
        t_text_word w;
        w = text_q.pop_back();
        w.eot = 1'b1;
        text_q.push_back(w);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(32, 255));
        end while (b == cbt_pkg::BYTE_QUOTE || b == cbt_pkg::BYTE_COMMA || b == sep_byte);
        return b;
    endfunction

    task automatic put_quoted(input int n);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                put_word(text_char(), 1'b0);
            end else if (roll == 5) begin
                put_word(cbt_pkg::BYTE_LF, 1'b0);
            end else if (roll == 6) begin
                put_word(cbt_pkg::BYTE_CR, 1'b0);
            end else if (roll == 7) begin
                put_word(cbt_pkg::BYTE_COMMA, 1'b0);
            end else if (roll == 8) begin
                put_word(sep_byte, 1'b0);
            end else begin
                put_word(cbt_pkg::BYTE_QUOTE, 1'b0);
                put_word(cbt_pkg::BYTE_QUOTE, 1'b0);
            end
        end
    endtask

    // One text of a few rows, with the final byte flagged as end of text.
    task automatic queue_text();
        int n_rows;
        int n_fields;
        int start;
        int roll;
        bit can_quote;
        start = text_q.size();
        can_quote = (sep_byte != cbt_pkg::BYTE_QUOTE);
        n_rows = $urandom_range(1, 4);
        for (int r = 0; r < n_rows; r++) begin
            n_fields = $urandom_range(1, 5);
            for (int f = 0; f < n_fields; f++) begin
                if (f != 0) put_word(sep_byte, 1'b0);
                roll = $urandom_range(0, 9);
                if (roll < 2) begin
                end else if (roll < 6 || !can_quote) begin
                    repeat ($urandom_range(1, 6)) put_word(text_char(), 1'b0);
                end else begin
                    put_word(cbt_pkg::BYTE_QUOTE, 1'b0);
                    put_quoted($urandom_range(0, 6));
                    put_word(cbt_pkg::BYTE_QUOTE, 1'b0);
                end
            end
            roll = (r == n_rows - 1) ? $urandom_range(0, 99) : $urandom_range(0, 39);
            if (roll < 20) begin
                put_word(cbt_pkg::BYTE_CR, 1'b0);
                put_word(cbt_pkg::BYTE_LF, 1'b0);
            end else if (roll < 40) begin
                put_word(cbt_pkg::BYTE_LF, 1'b0);
            end else if (roll < 70) begin
            end else if (roll < 85 || !can_quote) begin
                put_word(sep_byte, 1'b0);
            end else begin
                put_word(sep_byte, 1'b0);
                put_word(cbt_pkg::BYTE_QUOTE, 1'b0);
                put_quoted($urandom_range(0, 4));
            end
        end
        if (text_q.size() == start) put_word(text_char(), 1'b0);
        mark_end();
    endtask

    task automatic wait_drain();
        while (text_q.size() != 0 || expected_tags.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [7:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= DELIM_ADDR;
        pwdata <= {24'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            sep_byte = val;
        end else if (prdata[7:0] !== val) begin
            $error("delimiter: expected %0h, actual %0h", val, prdata[7:0]);
            fails++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        logic [7:0] seps [10];
        logic [7:0] d;
        t_fault fault;
        seps = '{8'd44, 8'd1, 8'd255, 8'd9, 8'd59, cbt_pkg::BYTE_LF, cbt_pkg::BYTE_CR,
                 cbt_pkg::BYTE_QUOTE, 8'd32, 8'd124};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_access(1'b0, cbt_pkg::DELIM_RESET);

        put_str(",,\012\015\012\"a,\015\012\"\"\"\015\012 !#+-");
        put_word(8'hFF, 1'b0);
        put_str("\012y,");
        mark_end();
        put_str("\"q");
        mark_end();
        wait_drain();

        for (int k = 0; k <= 10; k++) begin
            d = (k == 10) ? 8'($urandom_range(1, 255)) : seps[k];
            apb_access(1'b1, d);
            apb_access(1'b0, d);
            while (text_q.size() < 110) queue_text();
            wait_drain();
        end

        // Drive the column counter into saturation.
        apb_access(1'b1, cbt_pkg::BYTE_COMMA);
        repeat (300) put_word(cbt_pkg::BYTE_COMMA, 1'b0);
        put_word(8'h61, 1'b0);
        put_word(8'h7A, 1'b1);
        wait_drain();

        // The error is sticky until reset, so it closes the run.
        apb_access(1'b1, 8'd59);
        fault = t_fault'($urandom_range(0, 6));
        put_str("ab;");
        case (fault)
            FAULT_CTRL: begin
                put_str("a");
                put_word(8'($urandom_range(1, 8)), 1'b0);
            end
            FAULT_COMMA: put_word(cbt_pkg::BYTE_COMMA, 1'b0);
            FAULT_QUOTE_IN_FIELD: put_str("a\"");
            FAULT_AFTER_CLOSE: put_str("\"a\"b");
            FAULT_CTRL_QUOTED: begin
                put_str("\"a");
                put_word(8'($urandom_range(1, 8)), 1'b0);
            end
            FAULT_BARE_CR: put_str("a\015b");
            default: begin
                put_word(cbt_pkg::BYTE_CR, 1'b0);
                mark_end();
            end
        endcase
        repeat (8) put_word(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        wait_drain();

        if (fails == 0) begin
            $display("csv_byte_tokenizer_tb passed");
        end else begin
            $display("csv_byte_tokenizer_tb failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("csv_byte_tokenizer_tb failed");
        $finish;
    end

endmodule
